// ----- design/bca_pkg.sv -----
// Shared types and constants for the block chain allocator.
// No dependencies; bca_if, bca_link_tbl and the top level refer to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package bca_pkg;

   localparam int ID_W       = 6;   // block index / link entry width
   localparam int LEN_W      = 15;  // request byte length
   localparam int BL_W       = 9;   // block_len register
   localparam int CNT_W      = 7;   // block and free counts
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_WALK  = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_FIND  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_IN_USE   = 2'd1,
      STAT_OVERFLOW = 2'd2,
      STAT_NO_FREE  = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SEARCH = 4'd1;

   localparam logic [BL_W-1:0] BLOCK_LEN_RST    = 9'd16;
   localparam logic [ID_W-1:0] FIRST_SEARCH_RST = 6'd1;

   // One access to the link table: a read and a write per cycle.
   typedef struct packed {
      logic            rd_en;
      logic [ID_W-1:0] rd_addr;
      logic            wr_en;
      logic [ID_W-1:0] wr_addr;
      logic [ID_W-1:0] wr_data;
   } tbl_req_type;

endpackage

`default_nettype wire

// ----- design/bca_if.sv -----
// Channel interfaces for the block chain allocator: request, response, register write.
// Depends on bca_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bca_req_if;
   logic                        valid;
   logic                        ready;
   logic [bca_pkg::MODE_W-1:0]  mode;
   logic [bca_pkg::ID_W-1:0]    start_block;
   logic [bca_pkg::LEN_W-1:0]   byte_length;

   modport source (output valid, mode, start_block, byte_length, input ready);
   modport sink   (input valid, mode, start_block, byte_length, output ready);
endinterface

interface bca_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bca_pkg::ID_W-1:0]      block_id;
   logic                          last;
   logic [bca_pkg::STATUS_W-1:0]  status;
   logic [bca_pkg::CNT_W-1:0]     block_count;
   logic [bca_pkg::CNT_W-1:0]     free_count;

   modport source (output valid, block_id, last, status, block_count, free_count,
                   input ready);
   modport sink   (input valid, block_id, last, status, block_count, free_count,
                   output ready);
endinterface

interface bca_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bca_pkg::CSR_IDX_W-1:0]   index;
   logic [bca_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/block_chain_allocator.sv -----
// Block chain allocator top level: request sequencer, result buffer, output register.
// Depends on bca_pkg, bca_if, bca_ram and bca_link_tbl.
//
//   channel    dir   handshake        payload
//   req_chan   in    valid / ready    mode, start_block, byte_length
//   rsp_chan   out   valid / ready    block_id, last, status, block_count, free_count
//   csr_chan   in    valid / ready    index, data (always ready)
//
// The table is visited one entry at a time: walk and free follow the chain links,
// alloc claims free blocks and skips used entries, find_free scans upward from
// first_search_id. Chain results are buffered, then streamed at one per cycle while
// rsp_chan is ready, so every result carries the final free count.
// req_ready is high only between requests.
// Reset frees every block at once (one valid bit per block), no clearing pass.
// A stalled response holds the sequencer; the next request is taken while the final
// result of the previous one still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module block_chain_allocator #(
   parameter int NUM_BLOCKS = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   bca_req_if.sink   req_chan,
   bca_rsp_if.source rsp_chan,
   bca_csr_if.sink   csr_chan
);

   localparam int AW    = $clog2(NUM_BLOCKS);
   localparam int ID_W  = bca_pkg::ID_W;
   localparam int CNT_W = bca_pkg::CNT_W;
   localparam int LEN_W = bca_pkg::LEN_W;
   localparam int BL_W  = bca_pkg::BL_W;
   localparam logic [CNT_W-1:0] NB_CNT  = CNT_W'(NUM_BLOCKS);
   localparam logic [AW-1:0]    LAST_ID = AW'(NUM_BLOCKS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_CHK,
      S_CLAIM,
      S_SCAN,
      S_WALK,
      S_FIND,
      S_SINGLE,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   bca_pkg::mode_type       mode_ff, mode_in;
   bca_pkg::status_type     one_status_ff, one_status_in;
   bca_pkg::status_type     fin_status_ff, fin_status_in;
   logic [AW-1:0]           cur_ff, cur_in;
   logic [AW-1:0]           scan_ff, scan_in;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        free_ff, free_in;
   logic [BL_W-1:0]         blen_ff, blen_in;
   logic [ID_W-1:0]         fsid_ff, fsid_in;
   logic [ID_W-1:0]         one_id_ff, one_id_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    hold_ff, hold_in;
   logic [CNT_W-1:0]        hold_idx_ff, hold_idx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic                    rsp_last_ff, rsp_last_in;
   bca_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0]        rsp_free_ff, rsp_free_in;

   bca_pkg::tbl_req_type    tbl_req;
   logic [ID_W-1:0]         entry;
   logic                    buf_we;
   logic [AW-1:0]           buf_wa;
   logic [ID_W-1:0]         buf_wd;
   logic                    buf_re;
   logic [AW-1:0]           buf_ra;
   logic [ID_W-1:0]         buf_q;

   logic                    slot_free;
   logic [BL_W-1:0]         bl_eff;
   logic [AW-1:0]           cur_inc;
   logic [AW-1:0]           scan_inc;
   logic [CNT_W-1:0]        n_inc;
   logic [CNT_W-1:0]        hold_cnt;
   logic [CNT_W:0]          free_sum;
   logic                    walk_end;
   logic                    hold_last;

   bca_link_tbl #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_link_tbl (
      .clock (clock),
      .reset (reset),
      .req   (tbl_req),
      .entry (entry)
   );

   // chain block ids of the current request, replayed once its free count is final
   bca_ram #(
      .WIDTH (ID_W),
      .DEPTH (NUM_BLOCKS)
   ) u_result_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wa),
      .wr_data (buf_wd),
      .rd_en   (buf_re),
      .rd_addr (buf_ra),
      .rd_data (buf_q)
   );

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign bl_eff    = (blen_ff == '0) ? BL_W'(1) : blen_ff;
   assign cur_inc   = cur_ff + 1'b1;
   assign scan_inc  = scan_ff + 1'b1;
   assign n_inc     = n_ff + 1'b1;
   assign hold_cnt  = hold_idx_ff + 1'b1;
   assign hold_last = (hold_cnt == n_ff);
   assign free_sum  = {1'b0, free_ff} + {1'b0, n_inc};
   assign walk_end  = (entry == ID_W'(cur_ff)) || (CNT_W'(entry) >= NB_CNT)
                      || (n_inc >= NB_CNT);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      one_status_in = one_status_ff;
      fin_status_in = fin_status_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      free_in       = free_ff;
      blen_in       = blen_ff;
      fsid_in       = fsid_ff;
      one_id_in     = one_id_ff;
      issue_in      = issue_ff;
      hold_in       = hold_ff;
      hold_idx_in   = hold_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_free_in   = rsp_free_ff;
      tbl_req       = '0;
      buf_we        = 1'b0;
      buf_wa        = n_ff[AW-1:0];
      buf_wd        = ID_W'(cur_ff);
      buf_re        = 1'b0;
      buf_ra        = issue_ff[AW-1:0];

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bca_pkg::CSR_BLOCK_LEN:    blen_in = csr_chan.data[BL_W-1:0];
            bca_pkg::CSR_FIRST_SEARCH: fsid_in = csr_chan.data[ID_W-1:0];
            default: ;
         endcase
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in = bca_pkg::mode_type'(req_chan.mode);
               rem_in  = req_chan.byte_length;
               n_in    = '0;
               cur_in  = req_chan.start_block[AW-1:0];
               one_id_in     = '0;
               one_status_in = bca_pkg::STAT_OK;
               unique case (bca_pkg::mode_type'(req_chan.mode))
                  bca_pkg::MODE_ALLOC: begin
                     if (req_chan.byte_length == '0) begin
                        state_in = S_SINGLE;
                     end else if (CNT_W'(req_chan.start_block) >= NB_CNT) begin
                        one_status_in = bca_pkg::STAT_OVERFLOW;
                        state_in      = S_SINGLE;
                     end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = req_chan.start_block;
                        state_in        = S_ALLOC_CHK;
                     end
                  end
                  bca_pkg::MODE_WALK, bca_pkg::MODE_FREE: begin
                     if (CNT_W'(req_chan.start_block) >= NB_CNT) begin
                        state_in = S_SINGLE;
                     end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = req_chan.start_block;
                        state_in        = S_WALK;
                     end
                  end
                  bca_pkg::MODE_FIND: begin
                     if (free_ff == '0 || CNT_W'(fsid_ff) >= NB_CNT) begin
                        one_status_in = bca_pkg::STAT_NO_FREE;
                        state_in      = S_SINGLE;
                     end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = fsid_ff;
                        scan_in         = fsid_ff[AW-1:0];
                        state_in        = S_FIND;
                     end
                  end
               endcase
            end
         end

         S_ALLOC_CHK: begin
            if (entry != '0) begin
               one_id_in     = ID_W'(cur_ff);
               one_status_in = bca_pkg::STAT_IN_USE;
               state_in      = S_SINGLE;
            end else begin
               state_in = S_CLAIM;
            end
         end

         S_CLAIM: begin
            n_in    = n_inc;
            free_in = (free_ff == '0) ? '0 : free_ff - 1'b1;
            buf_we  = 1'b1;
            if (rem_ff <= LEN_W'(bl_eff)) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = ID_W'(cur_ff);
               tbl_req.wr_data = ID_W'(cur_ff);
               fin_status_in   = bca_pkg::STAT_OK;
               issue_in        = '0;
               hold_in         = 1'b0;
               state_in        = S_EMIT;
            end else begin
               rem_in = rem_ff - LEN_W'(bl_eff);
               if (cur_ff == LAST_ID) begin
                  tbl_req.wr_en   = 1'b1;
                  tbl_req.wr_addr = ID_W'(cur_ff);
                  tbl_req.wr_data = ID_W'(cur_ff);
                  fin_status_in   = bca_pkg::STAT_OVERFLOW;
                  issue_in        = '0;
                  hold_in         = 1'b0;
                  state_in        = S_EMIT;
               end else begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = ID_W'(cur_inc);
                  scan_in         = cur_inc;
                  state_in        = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (entry == '0) begin
               // link the current block to the free one, then claim it
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = ID_W'(cur_ff);
               tbl_req.wr_data = ID_W'(scan_ff);
               cur_in          = scan_ff;
               state_in        = S_CLAIM;
            end else if (scan_ff == LAST_ID) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = ID_W'(cur_ff);
               tbl_req.wr_data = ID_W'(cur_ff);
               fin_status_in   = bca_pkg::STAT_OVERFLOW;
               issue_in        = '0;
               hold_in         = 1'b0;
               state_in        = S_EMIT;
            end else begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = ID_W'(scan_inc);
               scan_in         = scan_inc;
            end
         end

         S_WALK: begin
            if (n_ff == '0 && entry == '0) begin
               state_in = S_SINGLE;
            end else begin
               n_in   = n_inc;
               buf_we = 1'b1;
               if (mode_ff == bca_pkg::MODE_FREE) begin
                  tbl_req.wr_en   = 1'b1;
                  tbl_req.wr_addr = ID_W'(cur_ff);
                  tbl_req.wr_data = '0;
               end
               if (walk_end) begin
                  if (mode_ff == bca_pkg::MODE_FREE) begin
                     free_in = (free_sum > {1'b0, NB_CNT}) ? NB_CNT : free_sum[CNT_W-1:0];
                  end
                  fin_status_in = bca_pkg::STAT_OK;
                  issue_in      = '0;
                  hold_in       = 1'b0;
                  state_in      = S_EMIT;
               end else begin
                  // next link differs from the current block
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = entry;
                  cur_in          = entry[AW-1:0];
               end
            end
         end

         S_FIND: begin
            if (entry == '0) begin
               one_id_in = ID_W'(scan_ff);
               state_in  = S_SINGLE;
            end else if (scan_ff == LAST_ID) begin
               one_status_in = bca_pkg::STAT_NO_FREE;
               state_in      = S_SINGLE;
            end else begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = ID_W'(scan_inc);
               scan_in         = scan_inc;
            end
         end

         S_SINGLE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = one_id_ff;
               rsp_last_in   = 1'b1;
               rsp_status_in = one_status_ff;
               rsp_count_in  = '0;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end
         end

         S_EMIT: begin
            if (hold_ff && slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = buf_q;
               rsp_last_in   = hold_last;
               rsp_status_in = hold_last ? fin_status_ff : bca_pkg::STAT_OK;
               rsp_count_in  = hold_cnt;
               rsp_free_in   = free_ff;
               hold_in       = 1'b0;
               if (hold_last) begin
                  state_in = S_IDLE;
               end
            end
            // prefetch the next buffered id when none is held or the held one drains this cycle
            if (issue_ff < n_ff && (!hold_ff || slot_free)) begin
               buf_re      = 1'b1;
               hold_in     = 1'b1;
               hold_idx_in = issue_ff;
               issue_in    = issue_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_ff      <= NB_CNT;
         blen_ff      <= bca_pkg::BLOCK_LEN_RST;
         fsid_ff      <= bca_pkg::FIRST_SEARCH_RST;
         hold_ff      <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         blen_ff      <= blen_in;
         fsid_ff      <= fsid_in;
         hold_ff      <= hold_in;
         n_ff         <= n_in;
      end
      mode_ff       <= mode_in;
      one_status_ff <= one_status_in;
      fin_status_ff <= fin_status_in;
      cur_ff        <= cur_in;
      scan_ff       <= scan_in;
      rem_ff        <= rem_in;
      one_id_ff     <= one_id_in;
      issue_ff      <= issue_in;
      hold_idx_ff   <= hold_idx_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.block_id    = rsp_id_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.block_count = rsp_count_ff;
   assign rsp_chan.free_count  = rsp_free_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= NB_CNT)
      else $error("free count above pool size");

   a_chain_len: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NB_CNT)
      else $error("chain length above pool size");

   a_mid_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
         (rsp_status_ff == bca_pkg::STAT_OK && rsp_count_ff != '0))
      else $error("non-final result with error status or zero count");

   a_hold_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && hold_ff) |-> (hold_idx_ff < n_ff))
      else $error("replay index past chain length");

   a_walk_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && mode_ff == bca_pkg::MODE_WALK) |=> $stable(free_ff))
      else $error("walk changed the free count");

endmodule

`default_nettype wire

// ----- design/bca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bca_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/bca_link_tbl.sv -----
// Link table: RAM of chain links plus one valid bit per block so reset frees all at once.
// Depends on bca_pkg and bca_ram.
`timescale 1ns / 1ps
`default_nettype none

module bca_link_tbl #(
   parameter int NUM_BLOCKS = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bca_pkg::tbl_req_type       req,
   output logic      [bca_pkg::ID_W-1:0]   entry
);

   localparam int AW = $clog2(NUM_BLOCKS);

   logic [NUM_BLOCKS-1:0]      vld_ff;
   logic                       vld_rd_ff;
   logic [bca_pkg::ID_W-1:0]   ram_q;

   bca_ram #(
      .WIDTH (bca_pkg::ID_W),
      .DEPTH (NUM_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr[AW-1:0]),
      .wr_data (req.wr_data),
      .rd_en   (req.rd_en),
      .rd_addr (req.rd_addr[AW-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            vld_ff[req.wr_addr[AW-1:0]] <= 1'b1;
         end
         if (req.rd_en) begin
            vld_rd_ff <= vld_ff[req.rd_addr[AW-1:0]];
         end
      end
   end

   // never-written entries read as free
   assign entry = vld_rd_ff ? ram_q : '0;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for block_chain_allocator: random and directed chain requests.
// Depends on bca_pkg and the channel interfaces in bca_if; predicts every result in-line.
`timescale 1ns / 1ps

module testbench;

   localparam int POOL       = 64;
   localparam int IDLE_PCT   = 18;
   localparam int LONG_HOLD  = 300;
   localparam int LIMIT_NS   = 4_000_000;
   localparam int ID_W       = bca_pkg::ID_W;
   localparam int LEN_W      = bca_pkg::LEN_W;
   localparam int CNT_W      = bca_pkg::CNT_W;
   localparam int CSR_IDX_W  = bca_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = bca_pkg::CSR_DATA_W;

   typedef struct {
      bca_pkg::mode_type mode;
      logic [ID_W-1:0]   start_block;
      logic [LEN_W-1:0]  byte_length;
   } chain_req_type;

   typedef struct {
      logic [ID_W-1:0]     block_id;
      logic                last;
      bca_pkg::status_type status;
      logic [CNT_W-1:0]    block_count;
      logic [CNT_W-1:0]    free_count;
   } chain_rsp_type;

   logic clock;
   logic reset;

   bca_req_if req_chan();
   bca_rsp_if rsp_chan();
   bca_csr_if csr_chan();

   block_chain_allocator #(.NUM_BLOCKS(POOL)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Shadow of the allocator state, owned by the monitor
   logic [ID_W-1:0] link_tbl [POOL];
   int              free_total;
   int              cfg_block_len;
   int              cfg_first_search;

   chain_req_type pending_reqs [$];
   chain_rsp_type chain_results_due [$];
   int            chain_heads [$];
   int            offered_count  = 0;
   int            accepted_count = 0;
   int            error_count    = 0;
   int            hold_requests  = 0;
   bit            no_idle        = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic chain_rsp_type make_rsp(int id, bit last, bca_pkg::status_type st,
                                              int count);
      chain_rsp_type r;
      r.block_id    = ID_W'(id);
      r.last        = last;
      r.status      = st;
      r.block_count = CNT_W'(count);
      r.free_count  = '0;
      return r;
   endfunction

   // Apply one accepted request to the shadow table and queue the results it causes
   function automatic void predict_chain_results(chain_req_type rq);
      chain_rsp_type res [$];
      int            bl, need, n, cur, nxt;
      bit            found, stop;
      case (rq.mode)
         bca_pkg::MODE_ALLOC: begin
            if (rq.byte_length == 0) begin
               res.push_back(make_rsp(0, 1, bca_pkg::STAT_OK, 0));
            end else if (int'(rq.start_block) >= POOL) begin
               res.push_back(make_rsp(0, 1, bca_pkg::STAT_OVERFLOW, 0));
            end else if (link_tbl[rq.start_block] != 0) begin
               res.push_back(make_rsp(rq.start_block, 1, bca_pkg::STAT_IN_USE, 0));
            end else begin
               bl   = (cfg_block_len == 0) ? 1 : cfg_block_len;
               need = (int'(rq.byte_length) + bl - 1) / bl;
               cur  = rq.start_block;
               n    = 0;
               stop = 0;
               while (!stop) begin
                  n++;
                  if (free_total > 0) free_total--;
                  if (n >= need) begin
                     link_tbl[cur] = ID_W'(cur);
                     res.push_back(make_rsp(cur, 1, bca_pkg::STAT_OK, n));
                     stop = 1;
                  end else begin
                     found = 0;
                     nxt   = cur + 1;
                     while (!found && nxt < POOL) begin
                        if (link_tbl[nxt] == 0) found = 1;
                        else nxt++;
                     end
                     if (!found) begin
                        // no room above: close the partial chain here
                        link_tbl[cur] = ID_W'(cur);
                        res.push_back(make_rsp(cur, 1, bca_pkg::STAT_OVERFLOW, n));
                        stop = 1;
                     end else begin
                        link_tbl[cur] = ID_W'(nxt);
                        res.push_back(make_rsp(cur, 0, bca_pkg::STAT_OK, n));
                        cur = nxt;
                     end
                  end
               end
            end
         end
         bca_pkg::MODE_WALK, bca_pkg::MODE_FREE: begin
            if (int'(rq.start_block) >= POOL || link_tbl[rq.start_block] == 0) begin
               res.push_back(make_rsp(0, 1, bca_pkg::STAT_OK, 0));
            end else begin
               cur  = rq.start_block;
               n    = 0;
               stop = 0;
               while (!stop) begin
                  nxt = link_tbl[cur];
                  n++;
                  stop = (nxt == cur) || (nxt >= POOL) || (n >= POOL);
                  if (rq.mode == bca_pkg::MODE_FREE) link_tbl[cur] = '0;
                  res.push_back(make_rsp(cur, stop, bca_pkg::STAT_OK, n));
                  cur = nxt;
               end
               if (rq.mode == bca_pkg::MODE_FREE) begin
                  free_total += n;
                  if (free_total > POOL) free_total = POOL;
               end
            end
         end
         default: begin
            found = 0;
            nxt   = cfg_first_search;
            if (free_total != 0) begin
               while (!found && nxt < POOL) begin
                  if (link_tbl[nxt] == 0) found = 1;
                  else nxt++;
               end
            end
            if (found) res.push_back(make_rsp(nxt, 1, bca_pkg::STAT_OK, 0));
            else res.push_back(make_rsp(0, 1, bca_pkg::STAT_NO_FREE, 0));
         end
      endcase
      foreach (res[i]) begin
         res[i].free_count = CNT_W'(free_total);
         chain_results_due.push_back(res[i]);
      end
   endfunction

   function automatic void check_result();
      chain_rsp_type exp_r;
      if (chain_results_due.size() == 0) begin
         $error("unexpected result: block_id %0d last %0d status %0d",
                rsp_chan.block_id, rsp_chan.last, rsp_chan.status);
         error_count++;
         return;
      end
      exp_r = chain_results_due.pop_front();
      if (rsp_chan.block_id !== exp_r.block_id) begin
         $error("block_id: expected %0d, got %0d", exp_r.block_id, rsp_chan.block_id);
         error_count++;
      end
      if (rsp_chan.last !== exp_r.last) begin
         $error("last: expected %0d, got %0d", exp_r.last, rsp_chan.last);
         error_count++;
      end
      if (rsp_chan.status !== exp_r.status) begin
         $error("status: expected %0d, got %0d", exp_r.status, rsp_chan.status);
         error_count++;
      end
      if (rsp_chan.block_count !== exp_r.block_count) begin
         $error("block_count: expected %0d, got %0d", exp_r.block_count,
                rsp_chan.block_count);
         error_count++;
      end
      if (rsp_chan.free_count !== exp_r.free_count) begin
         $error("free_count: expected %0d, got %0d", exp_r.free_count,
                rsp_chan.free_count);
         error_count++;
      end
   endfunction

   // Monitor: every transaction is sampled at the rising edge
   always @(posedge clock) begin : monitor
      chain_req_type rq;
      if (reset) begin
         foreach (link_tbl[i]) link_tbl[i] = '0;
         free_total       = POOL;
         cfg_block_len    = bca_pkg::BLOCK_LEN_RST;
         cfg_first_search = bca_pkg::FIRST_SEARCH_RST;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == bca_pkg::CSR_BLOCK_LEN) begin
               cfg_block_len = csr_chan.data;
            end else if (csr_chan.index == bca_pkg::CSR_FIRST_SEARCH) begin
               cfg_first_search = csr_chan.data[ID_W-1:0];
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         if (req_chan.valid && req_chan.ready) begin
            rq.mode        = bca_pkg::mode_type'(req_chan.mode);
            rq.start_block = req_chan.start_block;
            rq.byte_length = req_chan.byte_length;
            predict_chain_results(rq);
            accepted_count++;
         end
      end
   end

   // Request driver: hold the current transaction until it is taken
   always @(negedge clock) begin : req_driver
      chain_req_type rq;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (offered_count == accepted_count) begin
         if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
            rq = pending_reqs.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.mode        <= rq.mode;
            req_chan.start_block <= rq.start_block;
            req_chan.byte_length <= rq.byte_length;
            offered_count++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result backpressure, plus a long hold-off for each hold request
   always @(negedge clock) begin : rsp_stall
      int hold_left;
      int holds_served;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left    = 0;
         holds_served = 0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (holds_served != hold_requests) begin
         rsp_chan.ready <= 1'b0;
         hold_left = LONG_HOLD;
         holds_served++;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic queue_req(bca_pkg::mode_type m, int s, int len);
      chain_req_type rq;
      rq.mode        = m;
      rq.start_block = ID_W'(s);
      rq.byte_length = LEN_W'(len);
      pending_reqs.push_back(rq);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   task automatic wait_for_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || offered_count != accepted_count ||
                 chain_results_due.size() != 0);
   endtask

   // Mostly alloc, and walk / free on chains this run has started, plus find and noise
   task automatic queue_random_reqs(int count, int bl);
      int                r, s, len, idx;
      bca_pkg::mode_type m;
      repeat (count) begin
         r   = $urandom_range(0, 99);
         s   = $urandom_range(0, POOL - 1);
         len = $urandom_range(0, 16384);
         if (r < 8) begin
            m = bca_pkg::mode_type'($urandom_range(0, 3));
         end else if (r < 43) begin
            m = bca_pkg::MODE_ALLOC;
            if (chain_heads.size() != 0 && $urandom_range(0, 9) == 0)
               s = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
            if ($urandom_range(0, 19) != 0) len = $urandom_range(0, 4 * bl);
            chain_heads.push_back(s);
            if (chain_heads.size() > 16) void'(chain_heads.pop_front());
         end else if (r < 90) begin
            m = (r < 60) ? bca_pkg::MODE_WALK : bca_pkg::MODE_FREE;
            if (chain_heads.size() != 0) begin
               idx = $urandom_range(0, chain_heads.size() - 1);
               s   = chain_heads[idx];
               if (m == bca_pkg::MODE_FREE) chain_heads.delete(idx);
            end
         end else begin
            m = bca_pkg::MODE_FIND;
         end
         queue_req(m, s, len);
      end
   endtask

   initial begin : stimulus
      int bl_set [6] = '{1, 256, 0, 511, 16, 1};
      int fs_set [6] = '{0, 63, 32, 5, 1, 0};
      int bl;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.mode        = bca_pkg::MODE_ALLOC;
      req_chan.start_block = '0;
      req_chan.byte_length = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = bca_pkg::CSR_BLOCK_LEN;
      csr_chan.data        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // Directed sequence under the reset register values
      queue_req(bca_pkg::MODE_FIND, 63, 16384);
      queue_req(bca_pkg::MODE_ALLOC, 0, 0);
      queue_req(bca_pkg::MODE_ALLOC, 5, 40);
      queue_req(bca_pkg::MODE_ALLOC, 5, 1);
      queue_req(bca_pkg::MODE_ALLOC, 6, 16);
      queue_req(bca_pkg::MODE_WALK, 5, 0);
      queue_req(bca_pkg::MODE_WALK, 6, 0);
      queue_req(bca_pkg::MODE_WALK, 20, 0);
      queue_req(bca_pkg::MODE_FREE, 20, 0);
      queue_req(bca_pkg::MODE_ALLOC, 0, 16);
      queue_req(bca_pkg::MODE_WALK, 0, 0);
      queue_req(bca_pkg::MODE_ALLOC, 60, 100);
      queue_req(bca_pkg::MODE_WALK, 60, 0);
      queue_req(bca_pkg::MODE_ALLOC, 63, 1);
      queue_req(bca_pkg::MODE_FREE, 60, 0);
      queue_req(bca_pkg::MODE_ALLOC, 63, 17);
      queue_req(bca_pkg::MODE_FREE, 5, 0);
      queue_req(bca_pkg::MODE_ALLOC, 10, 16384);
      queue_req(bca_pkg::MODE_FIND, 0, 0);
      queue_req(bca_pkg::MODE_ALLOC, 1, 16384);
      queue_req(bca_pkg::MODE_FIND, 0, 0);
      queue_req(bca_pkg::MODE_WALK, 10, 0);
      queue_req(bca_pkg::MODE_FREE, 10, 0);
      queue_req(bca_pkg::MODE_FREE, 1, 0);
      queue_req(bca_pkg::MODE_FREE, 63, 0);
      wait_for_idle();

      bl_set[5] = $urandom_range(1, 256);
      fs_set[5] = $urandom_range(0, POOL - 1);
      for (int p = 0; p < 6; p++) begin
         no_idle = (p == 1);
         if (p == 0) hold_requests++;
         write_csr(bca_pkg::CSR_BLOCK_LEN, bl_set[p]);
         write_csr(bca_pkg::CSR_FIRST_SEARCH, fs_set[p]);
         bl = (bl_set[p] == 0) ? 1 : bl_set[p];
         if (p == 2) begin
            // pause the sender mid-phase until all results are back
            queue_random_reqs(24, bl);
            wait_for_idle();
            queue_random_reqs(24, bl);
         end else begin
            queue_random_reqs(48, bl);
         end
         wait_for_idle();
      end

      repeat (3 * POOL + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- block_chain_allocator.f -----
design/bca_pkg.sv
design/bca_if.sv
design/bca_ram.sv
design/bca_link_tbl.sv
design/block_chain_allocator.sv
sim/testbench.sv
